// ----- sv/i2cadc_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cadc_pkg
// Types and constants shared by the I2C converter read sequencer.
// ----------------------------------------------------------------------------
package i2cadc_pkg;

  localparam int STEP_W = 4;
  localparam int IDX_W  = 3;

  localparam logic [STEP_W-1:0] ST_IDLE        = 4'd0;
  localparam logic [STEP_W-1:0] ST_START1      = 4'd1;
  localparam logic [STEP_W-1:0] ST_SEND_WADDR  = 4'd2;
  localparam logic [STEP_W-1:0] ST_ACK_WADDR   = 4'd3;
  localparam logic [STEP_W-1:0] ST_SEND_CTRL   = 4'd4;
  localparam logic [STEP_W-1:0] ST_ACK_CTRL    = 4'd5;
  localparam logic [STEP_W-1:0] ST_START2      = 4'd6;
  localparam logic [STEP_W-1:0] ST_SEND_RADDR  = 4'd7;
  localparam logic [STEP_W-1:0] ST_ACK_RADDR   = 4'd8;
  localparam logic [STEP_W-1:0] ST_RECV_DUMMY  = 4'd9;
  localparam logic [STEP_W-1:0] ST_MACK_DUMMY  = 4'd10;
  localparam logic [STEP_W-1:0] ST_RECV_SAMPLE = 4'd11;
  localparam logic [STEP_W-1:0] ST_MACK_SAMPLE = 4'd12;
  localparam logic [STEP_W-1:0] ST_NOACK       = 4'd13;
  localparam logic [STEP_W-1:0] ST_STOP_OK     = 4'd14;
  localparam logic [STEP_W-1:0] ST_STOP_ERR    = 4'd15;

  localparam logic [7:0] ADDR_WRITE = 8'h90;
  localparam logic [7:0] ADDR_READ  = 8'h91;
  localparam logic [7:0] CTRL_RESET = 8'h04;

  typedef struct packed {
    logic start_req;
    logic sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       failed;
    logic       sample_valid;
    logic [1:0] sample_channel;
    logic [7:0] sample_value;
  } out_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [1:0]        bit_phase;
    logic [2:0]        bit_count;
    logic [7:0]        shift_byte;
    logic [IDX_W-1:0]  sample_index;
    logic              retry_used;
  } seq_state_t;

endpackage

// ----- sv/i2cadc_step.sv -----
// ----------------------------------------------------------------------------
// i2cadc_step
// One bus tick of the read sequencer: line levels, flags and next state.
// ----------------------------------------------------------------------------
module i2cadc_step #(
  parameter int SAMPLE_COUNT = 4
) (
  input  i2cadc_pkg::seq_state_t st,
  input  i2cadc_pkg::in_t        din,
  input  logic [7:0]             control_byte,
  output i2cadc_pkg::seq_state_t st_nxt,
  output i2cadc_pkg::out_t       res
);
  import i2cadc_pkg::*;

  seq_state_t            cur;
  logic [1:0]            ph;
  logic [7:0]            rx_byte;
  logic [IDX_W-1:0]      idx_inc;

  always_comb begin
    cur = st;
    ph  = st.bit_phase;
    if (st.step == ST_IDLE && din.start_req) begin
      cur.retry_used = 1'b0;
      cur.step       = ST_START1;
      cur.bit_phase  = 2'd0;
      ph             = 2'd0;
    end

    rx_byte = {cur.shift_byte[6:0], din.sda_in};
    idx_inc = cur.sample_index + IDX_W'(1);
    st_nxt  = cur;

    res                = '0;
    res.scl            = 1'b1;
    res.sda_drive      = 1'b1;
    res.busy_res       = (cur.step != ST_IDLE);

    case (cur.step)
      ST_IDLE: begin
      end
      ST_START1, ST_START2: begin
        res.scl       = (ph != 2'd0);
        res.sda_drive = (ph != 2'd2);
        if (ph >= 2'd2) begin
          st_nxt.step       = (cur.step == ST_START1) ? ST_SEND_WADDR : ST_SEND_RADDR;
          st_nxt.shift_byte = (cur.step == ST_START1) ? ADDR_WRITE : ADDR_READ;
          st_nxt.bit_count  = 3'd0;
          st_nxt.bit_phase  = 2'd0;
        end else begin
          st_nxt.bit_phase = ph + 2'd1;
        end
      end
      ST_SEND_WADDR, ST_SEND_CTRL, ST_SEND_RADDR: begin
        res.scl       = (ph != 2'd0);
        res.sda_drive = cur.shift_byte[7];
        if (ph == 2'd0) begin
          st_nxt.bit_phase = 2'd1;
        end else begin
          st_nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
          st_nxt.bit_phase  = 2'd0;
          st_nxt.bit_count  = cur.bit_count + 3'd1;
          if (cur.bit_count == 3'd7) begin
            st_nxt.step = cur.step + STEP_W'(1);
          end
        end
      end
      ST_ACK_WADDR, ST_ACK_CTRL, ST_ACK_RADDR: begin
        res.scl = (ph != 2'd0);
        if (ph == 2'd0) begin
          st_nxt.bit_phase = 2'd1;
        end else begin
          st_nxt.bit_phase = 2'd0;
          if (din.sda_in) begin
            st_nxt.step = ST_STOP_ERR;
          end else if (cur.step == ST_ACK_WADDR) begin
            st_nxt.step       = ST_SEND_CTRL;
            st_nxt.shift_byte = control_byte;
            st_nxt.bit_count  = 3'd0;
          end else if (cur.step == ST_ACK_CTRL) begin
            st_nxt.step = ST_START2;
          end else begin
            st_nxt.step       = ST_RECV_DUMMY;
            st_nxt.bit_count  = 3'd0;
            st_nxt.shift_byte = 8'd0;
          end
        end
      end
      ST_RECV_DUMMY, ST_RECV_SAMPLE: begin
        res.scl = (ph != 2'd0);
        if (ph == 2'd0) begin
          st_nxt.bit_phase = 2'd1;
        end else begin
          st_nxt.shift_byte = rx_byte;
          st_nxt.bit_phase  = 2'd0;
          st_nxt.bit_count  = cur.bit_count + 3'd1;
          if (cur.bit_count == 3'd7) begin
            st_nxt.step = cur.step + STEP_W'(1);
            if (cur.step == ST_RECV_SAMPLE) begin
              res.sample_valid   = 1'b1;
              res.sample_channel = cur.sample_index[1:0];
              res.sample_value   = rx_byte;
            end
          end
        end
      end
      ST_MACK_DUMMY, ST_MACK_SAMPLE: begin
        res.scl       = (ph != 2'd0);
        res.sda_drive = 1'b0;
        if (ph == 2'd0) begin
          st_nxt.bit_phase = 2'd1;
        end else begin
          st_nxt.bit_phase  = 2'd0;
          st_nxt.shift_byte = 8'd0;
          if (cur.step == ST_MACK_DUMMY) begin
            st_nxt.sample_index = '0;
            st_nxt.step         = ST_RECV_SAMPLE;
          end else begin
            st_nxt.sample_index = idx_inc;
            st_nxt.step = (idx_inc >= IDX_W'(SAMPLE_COUNT)) ? ST_NOACK : ST_RECV_SAMPLE;
          end
        end
      end
      ST_NOACK: begin
        res.scl = (ph != 2'd0);
        if (ph == 2'd0) begin
          st_nxt.bit_phase = 2'd1;
        end else begin
          st_nxt.bit_phase = 2'd0;
          st_nxt.step      = ST_STOP_OK;
        end
      end
      default: begin
        res.scl       = (ph != 2'd0);
        res.sda_drive = (ph >= 2'd2);
        if (ph < 2'd2) begin
          st_nxt.bit_phase = ph + 2'd1;
        end else begin
          st_nxt.bit_phase = 2'd0;
          st_nxt.bit_count = 3'd0;
          if (cur.step == ST_STOP_OK) begin
            res.done_res = 1'b1;
            st_nxt.step  = ST_IDLE;
          end else if (!cur.retry_used) begin
            st_nxt.retry_used = 1'b1;
            st_nxt.step       = ST_START1;
          end else begin
            res.failed  = 1'b1;
            st_nxt.step = ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

// ----- sv/i2c_master_adc_four_channel_read_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_master_adc_four_channel_read_unit
// I2C master that reads a four-channel converter, one bus tick per beat.
// A taken beat passes the input register, then the result register.
// Throughput: one beat per cycle while the result side is not stalled; the
// sequencer state advances once per tick. The input register and the result
// register each hold one beat. Reset (synchronous, rst_n low) returns the
// sequencer to idle and the control byte to its default.
// ----------------------------------------------------------------------------
module i2c_master_adc_four_channel_read_unit #(
  parameter int SAMPLE_COUNT = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2cadc_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cadc_pkg::out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);
  import i2cadc_pkg::*;

  logic       in_valid_r;
  in_t        in_data_r;
  logic       out_valid_r;
  out_t       out_data_r;
  logic [7:0] control_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_t       res;
  logic       step_adv;

  assign step_adv  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cadc_step #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_step (
    .st           (st_r),
    .din          (in_data_r),
    .control_byte (control_r),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      control_r   <= CTRL_RESET;
      st_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        control_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step_adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (step_adv) begin
      out_data_r <= res;
    end
  end

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.step == ST_IDLE |-> st_r.bit_phase == 2'd0)
    else $error("idle sequencer holds a nonzero bit phase");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_adv && !res.busy_res |=> st_r.step == ST_IDLE)
    else $error("non-busy tick left the sequencer out of idle");

  a_end_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.done_res || out_data_r.failed) |->
      out_data_r.busy_res && out_data_r.scl && out_data_r.sda_drive)
    else $error("run ended off the final stop tick");

  a_sample_on_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.sample_valid |-> out_data_r.busy_res && out_data_r.scl)
    else $error("sample reported outside a high clock tick");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.sample_index <= IDX_W'(SAMPLE_COUNT))
    else $error("sample index ran past the sample count");

endmodule
